### hw/rtl/ogst_pkg.sv
// ----------------------------------------------------------------------------
// Obstacle-gated speed target: shared package
// Function codes, register indexes, sequencer states and the command word
// of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package ogst_pkg;

   localparam int ALPHA_Q8              = 128;
   localparam int ALPHA_REST_Q8         = 256 - ALPHA_Q8;
   localparam int RADAR_ANGLE_LIMIT_Q12 = 4289;
   localparam int INV_HEADWAY_CAP       = 2560;

   localparam logic [15:0] NONE16 = 16'hFFFF;

   typedef enum logic [2:0] {
      FUNC_LIDAR_POINT = 3'd0,
      FUNC_LIDAR_FRAME = 3'd1,
      FUNC_RADAR_DET   = 3'd2,
      FUNC_RADAR_FRAME = 3'd3,
      FUNC_TICK        = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      CSR_MAX_SPEED         = 3'd0,
      CSR_MIN_SPEED         = 3'd1,
      CSR_STOP_DISTANCE     = 3'd2,
      CSR_INV_HEADWAY       = 3'd3,
      CSR_MAX_RANGE         = 3'd4,
      CSR_HALF_LANE         = 3'd5,
      CSR_TAN_FRONT_ANGLE   = 3'd6,
      CSR_EMERGENCY_CLOSURE = 3'd7
   } csr_index_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LCHK = 7'b0000010,
      ST_TMUL = 7'b0000100,
      ST_TLAW = 7'b0001000,
      ST_SM1  = 7'b0010000,
      ST_SM2  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic        en;
      logic        acc;
      logic [15:0] a;
      logic [15:0] b;
   } mac_cmd_type;

endpackage

### hw/rtl/ogst_req_if.sv
// ----------------------------------------------------------------------------
// Obstacle-gated speed target: input channel
// Carries one sensor or control word with valid and ready.
// ----------------------------------------------------------------------------
interface ogst_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [15:0] lidar_x;
   logic signed [15:0] lidar_y;
   logic signed [15:0] radar_distance;
   logic signed [14:0] radar_angle;
   logic signed [14:0] radar_rel_vel;
   logic               values_finite;

   modport source (
      output valid, func, lidar_x, lidar_y, radar_distance, radar_angle,
             radar_rel_vel, values_finite,
      input  ready
   );
   modport sink (
      input  valid, func, lidar_x, lidar_y, radar_distance, radar_angle,
             radar_rel_vel, values_finite,
      output ready
   );
endinterface

### hw/rtl/ogst_rsp_if.sv
// ----------------------------------------------------------------------------
// Obstacle-gated speed target: result channel
// Carries one speed target word with valid and ready.
// ----------------------------------------------------------------------------
interface ogst_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] speed_cmd;
   logic [14:0] nearest_distance;
   logic        obstacle_seen;
   logic        emergency_cap_applied;

   modport source (
      output valid, speed_cmd, nearest_distance, obstacle_seen,
             emergency_cap_applied,
      input  ready
   );
   modport sink (
      input  valid, speed_cmd, nearest_distance, obstacle_seen,
             emergency_cap_applied,
      output ready
   );
endinterface

### hw/rtl/ogst_csr_if.sv
// ----------------------------------------------------------------------------
// Obstacle-gated speed target: configuration write channel
// Carries a register index and write data with valid and ready.
// ----------------------------------------------------------------------------
interface ogst_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/obstacle_gated_speed_target.sv
// ----------------------------------------------------------------------------
// Obstacle-gated speed target
// Gates lidar points and radar detections, keeps the nearest of each per
// frame and turns the nearer latched obstacle into a smoothed time-gap
// speed target on each control tick.
//
//   Channel  Dir  Word
//   req_ch   in   func, lidar x/y, radar distance/angle/velocity, finite flag
//   rsp_ch   out  target speed, nearest distance, seen flag, cap flag
//   csr_ch   in   register index and write data
//
// Frame ends and radar detections finish in the idle state; lidar points
// add a check step on the shared multiplier's product. A tick runs the
// head-way product, clamp and cap, two smoothing products and the final
// clamp, the products through the one shared multiplier. The result sits
// in an output register; a tick waits in its final clamp step only while
// the previous result is still not taken. Reset restores the settings,
// the frame minimums, the smoothed speed and the control state.
// ----------------------------------------------------------------------------
module obstacle_gated_speed_target (
   input logic         clock,
   input logic         reset,
   ogst_req_if.sink    req_ch,
   ogst_rsp_if.source  rsp_ch,
   ogst_csr_if.sink    csr_ch
);
   import ogst_pkg::*;

   state_type state_ff, state_in;

   logic [13:0]        max_speed_ff;
   logic [13:0]        min_speed_ff;
   logic [14:0]        stop_dist_ff;
   logic [11:0]        inv_headway_ff;
   logic [14:0]        max_range_ff;
   logic [14:0]        half_lane_ff;
   logic [15:0]        tan_front_ff;
   logic signed [14:0] emerg_closure_ff;

   logic [15:0]        lidar_run_ff, lidar_run_in;
   logic [15:0]        lidar_lat_ff, lidar_lat_in;
   logic [15:0]        radar_run_ff, radar_run_in;
   logic signed [14:0] radar_run_vel_ff, radar_run_vel_in;
   logic [15:0]        radar_lat_ff, radar_lat_in;
   logic signed [14:0] radar_lat_vel_ff, radar_lat_vel_in;
   logic [13:0]        smoothed_ff, smoothed_in;

   logic [15:0] lx_ff, lx_in;
   logic [15:0] ay_ff, ay_in;
   logic        lok_ff, lok_in;
   logic [15:0] d_ff, d_in;
   logic [13:0] v_ff, v_in;
   logic        capped_ff, capped_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [13:0] rsp_speed_ff, rsp_speed_in;
   logic [14:0] rsp_dist_ff, rsp_dist_in;
   logic        rsp_seen_ff, rsp_seen_in;
   logic        rsp_cap_ff, rsp_cap_in;

   mac_cmd_type mac_cmd;
   logic [31:0] mac_prod;

   logic        req_fire;
   logic        out_free;
   logic        seen;
   logic [15:0] ra_abs;
   logic [15:0] ly_abs;
   logic [11:0] ih_eff;
   logic [13:0] v_law;
   logic signed [15:0] cap_s;
   logic [14:0] cap_u;
   logic [23:0] s_raw;
   logic [13:0] s_sat;

   function automatic logic [13:0] clamp_speed(input logic [23:0] v,
                                               input logic [13:0] lo,
                                               input logic [13:0] hi);
      logic [23:0] t;
      t = v;
      if (t < 24'(lo)) begin
         t = 24'(lo);
      end
      if (t > 24'(hi)) begin
         t = 24'(hi);
      end
      return t[13:0];
   endfunction

   ogst_mac u_mac (
      .clock (clock),
      .cmd   (mac_cmd),
      .prod  (mac_prod)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign seen         = (d_ff != NONE16);

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid                 = rsp_valid_ff;
   assign rsp_ch.speed_cmd             = rsp_speed_ff;
   assign rsp_ch.nearest_distance      = rsp_dist_ff;
   assign rsp_ch.obstacle_seen         = rsp_seen_ff;
   assign rsp_ch.emergency_cap_applied = rsp_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff     <= 14'd2560;
         min_speed_ff     <= 14'd0;
         stop_dist_ff     <= 15'd512;
         inv_headway_ff   <= 12'd171;
         max_range_ff     <= 15'd12800;
         half_lane_ff     <= 15'd448;
         tan_front_ff     <= 16'd443;
         emerg_closure_ff <= -15'sd1280;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_MAX_SPEED:         max_speed_ff     <= csr_ch.data[13:0];
            CSR_MIN_SPEED:         min_speed_ff     <= csr_ch.data[13:0];
            CSR_STOP_DISTANCE:     stop_dist_ff     <= csr_ch.data[14:0];
            CSR_INV_HEADWAY:       inv_headway_ff   <= csr_ch.data[11:0];
            CSR_MAX_RANGE:         max_range_ff     <= csr_ch.data[14:0];
            CSR_HALF_LANE:         half_lane_ff     <= csr_ch.data[14:0];
            CSR_TAN_FRONT_ANGLE:   tan_front_ff     <= csr_ch.data;
            CSR_EMERGENCY_CLOSURE: emerg_closure_ff <= csr_ch.data[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ly_abs = req_ch.lidar_y[15] ? (~req_ch.lidar_y + 16'd1) : req_ch.lidar_y;
      ra_abs = req_ch.radar_angle[14] ? (~16'(req_ch.radar_angle) + 16'd1)
                                      : 16'(req_ch.radar_angle);
      ih_eff = (inv_headway_ff > 12'(INV_HEADWAY_CAP)) ? 12'(INV_HEADWAY_CAP)
                                                       : inv_headway_ff;
      v_law  = clamp_speed(mac_prod[31:8], min_speed_ff, max_speed_ff);
      cap_s  = 16'(max_speed_ff) + 16'(radar_lat_vel_ff);
      cap_u  = cap_s[15] ? 15'd0 : cap_s[14:0];
      s_raw  = mac_prod[31:8];
      s_sat  = (s_raw > 24'h3FFF) ? 14'h3FFF : s_raw[13:0];
   end

   always_comb begin
      state_in         = state_ff;
      lidar_run_in     = lidar_run_ff;
      lidar_lat_in     = lidar_lat_ff;
      radar_run_in     = radar_run_ff;
      radar_run_vel_in = radar_run_vel_ff;
      radar_lat_in     = radar_lat_ff;
      radar_lat_vel_in = radar_lat_vel_ff;
      smoothed_in      = smoothed_ff;
      lx_in            = lx_ff;
      ay_in            = ay_ff;
      lok_in           = lok_ff;
      d_in             = d_ff;
      v_in             = v_ff;
      capped_in        = capped_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_speed_in     = rsp_speed_ff;
      rsp_dist_in      = rsp_dist_ff;
      rsp_seen_in      = rsp_seen_ff;
      rsp_cap_in       = rsp_cap_ff;
      mac_cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (func_type'(req_ch.func))
                  FUNC_LIDAR_POINT: begin
                     lx_in   = req_ch.lidar_x;
                     ay_in   = ly_abs;
                     lok_in  = req_ch.values_finite && !req_ch.lidar_x[15] &&
                               (req_ch.lidar_x != 16'sd0) &&
                               (req_ch.lidar_x[14:0] <= max_range_ff) &&
                               (ly_abs <= 16'(half_lane_ff));
                     mac_cmd = '{en: 1'b1, acc: 1'b0,
                                 a: req_ch.lidar_x, b: tan_front_ff};
                     state_in = ST_LCHK;
                  end
                  FUNC_LIDAR_FRAME: begin
                     lidar_lat_in = lidar_run_ff;
                     lidar_run_in = NONE16;
                  end
                  FUNC_RADAR_DET: begin
                     if (req_ch.values_finite && !req_ch.radar_distance[15] &&
                         (req_ch.radar_distance != 16'sd0) &&
                         (req_ch.radar_distance[14:0] <= max_range_ff) &&
                         (ra_abs <= 16'(RADAR_ANGLE_LIMIT_Q12)) &&
                         (req_ch.radar_distance < radar_run_ff)) begin
                        radar_run_in     = req_ch.radar_distance;
                        radar_run_vel_in = req_ch.radar_rel_vel;
                     end
                  end
                  FUNC_RADAR_FRAME: begin
                     radar_lat_in     = radar_run_ff;
                     radar_lat_vel_in = radar_run_vel_ff;
                     radar_run_in     = NONE16;
                     radar_run_vel_in = '0;
                  end
                  FUNC_TICK: begin
                     d_in     = (lidar_lat_ff < radar_lat_ff) ? lidar_lat_ff
                                                              : radar_lat_ff;
                     state_in = ST_TMUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_LCHK: begin
            if (lok_ff && ({8'd0, ay_ff, 8'd0} <= mac_prod) &&
                (lx_ff < lidar_run_ff)) begin
               lidar_run_in = lx_ff;
            end
            state_in = ST_IDLE;
         end
         ST_TMUL: begin
            mac_cmd  = '{en: 1'b1, acc: 1'b0,
                         a: d_ff - 16'(stop_dist_ff), b: 16'(ih_eff)};
            state_in = ST_TLAW;
         end
         ST_TLAW: begin
            priority if (!seen) begin
               v_in = max_speed_ff;
            end else if (d_ff <= 16'(stop_dist_ff)) begin
               v_in = 14'd0;
            end else begin
               v_in = v_law;
            end
            capped_in = 1'b0;
            if ((radar_lat_vel_ff < emerg_closure_ff) && (cap_u < 15'(v_in))) begin
               v_in      = cap_u[13:0];
               capped_in = 1'b1;
            end
            state_in = ST_SM1;
         end
         ST_SM1: begin
            mac_cmd  = '{en: 1'b1, acc: 1'b0, a: 16'(ALPHA_Q8), b: 16'(v_ff)};
            state_in = ST_SM2;
         end
         ST_SM2: begin
            mac_cmd  = '{en: 1'b1, acc: 1'b1, a: 16'(ALPHA_REST_Q8),
                         b: 16'(smoothed_ff)};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               smoothed_in  = clamp_speed(24'(s_sat), min_speed_ff, max_speed_ff);
               rsp_valid_in = 1'b1;
               rsp_speed_in = smoothed_in;
               rsp_dist_in  = seen ? d_ff[14:0] : 15'd0;
               rsp_seen_in  = seen;
               rsp_cap_in   = capped_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         lidar_run_ff     <= NONE16;
         lidar_lat_ff     <= NONE16;
         radar_run_ff     <= NONE16;
         radar_run_vel_ff <= '0;
         radar_lat_ff     <= NONE16;
         radar_lat_vel_ff <= '0;
         smoothed_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         lidar_run_ff     <= lidar_run_in;
         lidar_lat_ff     <= lidar_lat_in;
         radar_run_ff     <= radar_run_in;
         radar_run_vel_ff <= radar_run_vel_in;
         radar_lat_ff     <= radar_lat_in;
         radar_lat_vel_ff <= radar_lat_vel_in;
         smoothed_ff      <= smoothed_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lx_ff        <= lx_in;
      ay_ff        <= ay_in;
      lok_ff       <= lok_in;
      d_ff         <= d_in;
      v_ff         <= v_in;
      capped_ff    <= capped_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_seen_ff  <= rsp_seen_in;
      rsp_cap_ff   <= rsp_cap_in;
   end

   // A new result word is only ever produced by the final smoothing step.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result word appeared outside the final step");

   // The seen flag and a nonzero distance always travel together.
   a_seen_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_seen_ff == (rsp_dist_ff != 15'd0)))
      else $error("seen flag disagrees with nearest distance");

   // A lidar point can only lower the running minimum.
   a_lidar_min: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.func == FUNC_LIDAR_POINT)) |=> ##1
      (lidar_run_ff <= $past(lidar_run_ff, 2)))
      else $error("lidar running minimum increased on a point");

   // A tick never leaves the idle state without entering the multiply step.
   a_tick_seq: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.func == FUNC_TICK)) |=> (state_ff == ST_TMUL))
      else $error("tick did not start the headway product");
endmodule

### hw/rtl/ogst_mac.sv
// ----------------------------------------------------------------------------
// Obstacle-gated speed target: shared multiply-accumulate unit
// One 16 x 16 multiplier with a registered product that can add onto
// the previous product.
// ----------------------------------------------------------------------------
module ogst_mac (
   input  logic                 clock,
   input  ogst_pkg::mac_cmd_type cmd,
   output logic [31:0]          prod
);
   import ogst_pkg::*;

   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   always_comb begin
      prod_in = (cmd.acc ? prod_ff : 32'd0) + (32'(cmd.a) * 32'(cmd.b));
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule

### verif/obstacle_gated_speed_target_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Obstacle-gated speed target: scoreboard checker
// Watches the sensor, result and register channels of the block. It keeps
// its own copy of the registers, the per-frame minimums and the smoothed
// speed, predicts every speed target word at each accepted tick and compares
// each accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module obstacle_gated_speed_target_checker (
   input  logic clock,
   input  logic reset,
   ogst_req_if  req_ch,
   ogst_rsp_if  rsp_ch,
   ogst_csr_if  csr_ch,
   output int   failures,
   output int   pending,
   output int   targets_checked,
   output int   caps_checked
);
   import ogst_pkg::*;

   localparam int SPEED_CEILING = 16383;

   typedef struct packed {
      logic [13:0] speed;
      logic [14:0] distance;
      logic        seen;
      logic        capped;
   } speed_word_type;

   speed_word_type expected_targets[$];

   logic [13:0]        max_speed_r;
   logic [13:0]        min_speed_r;
   logic [14:0]        stop_distance_r;
   logic [11:0]        inv_headway_r;
   logic [14:0]        max_range_r;
   logic [14:0]        half_lane_r;
   logic [15:0]        tan_front_r;
   logic signed [14:0] closure_r;

   logic [15:0]        lidar_running;
   logic [15:0]        lidar_latched;
   logic [15:0]        radar_running;
   logic [15:0]        radar_latched;
   logic signed [14:0] radar_running_vel;
   logic signed [14:0] radar_latched_vel;
   logic [13:0]        smoothed;

   // The lower limit is applied first, so the upper one wins when they cross.
   function automatic int bound_speed(input int value);
      int r;
      r = value;
      if (r < int'(min_speed_r)) r = int'(min_speed_r);
      if (r > int'(max_speed_r)) r = int'(max_speed_r);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t ns: %s is %0d, expected %0d", $time, field, got, want);
      failures++;
   endtask

   task automatic clear_state();
      max_speed_r       = 14'd2560;
      min_speed_r       = 14'd0;
      stop_distance_r   = 15'd512;
      inv_headway_r     = 12'd171;
      max_range_r       = 15'd12800;
      half_lane_r       = 15'd448;
      tan_front_r       = 16'd443;
      closure_r         = -15'sd1280;
      lidar_running     = NONE16;
      lidar_latched     = NONE16;
      radar_running     = NONE16;
      radar_latched     = NONE16;
      radar_running_vel = '0;
      radar_latched_vel = '0;
      smoothed          = '0;
      failures          = 0;
      targets_checked   = 0;
      caps_checked      = 0;
      expected_targets.delete();
   endtask

   task automatic write_setting(input logic [2:0] idx, input logic [15:0] data);
      case (csr_index_type'(idx))
         CSR_MAX_SPEED:         max_speed_r = data[13:0];
         CSR_MIN_SPEED:         min_speed_r = data[13:0];
         CSR_STOP_DISTANCE:     stop_distance_r = data[14:0];
         CSR_INV_HEADWAY:       inv_headway_r = data[11:0];
         CSR_MAX_RANGE:         max_range_r = data[14:0];
         CSR_HALF_LANE:         half_lane_r = data[14:0];
         CSR_TAN_FRONT_ANGLE:   tan_front_r = data;
         CSR_EMERGENCY_CLOSURE: closure_r = data[14:0];
         default: ;
      endcase
   endtask

   task automatic predict_tick();
      int             nearest;
      int             speed;
      int             cap;
      int             headway;
      int             mix;
      bit             seen;
      bit             capped;
      speed_word_type t;
      nearest = (lidar_latched < radar_latched) ? int'(lidar_latched) : int'(radar_latched);
      seen    = (nearest != int'(NONE16));
      capped  = 1'b0;
      if (!seen) begin
         speed = int'(max_speed_r);
      end else if (nearest <= int'(stop_distance_r)) begin
         speed = 0;
      end else begin
         headway = (int'(inv_headway_r) > INV_HEADWAY_CAP) ? INV_HEADWAY_CAP
                                                           : int'(inv_headway_r);
         speed = bound_speed(((nearest - int'(stop_distance_r)) * headway) >>> 8);
      end
      if (int'(radar_latched_vel) < int'(closure_r)) begin
         cap = int'(max_speed_r) + int'(radar_latched_vel);
         if (cap < 0) cap = 0;
         if (cap < speed) begin
            speed  = cap;
            capped = 1'b1;
         end
      end
      mix = (ALPHA_Q8 * speed + ALPHA_REST_Q8 * int'(smoothed)) >>> 8;
      if (mix > SPEED_CEILING) mix = SPEED_CEILING;
      smoothed   = 14'(bound_speed(mix));
      t.speed    = smoothed;
      t.distance = seen ? nearest[14:0] : '0;
      t.seen     = seen;
      t.capped   = capped;
      expected_targets.insert(expected_targets.size(), t);
   endtask

   task automatic predict_word();
      int x;
      int y;
      int ay;
      int det_range;
      int ang;
      int ang_abs;
      bit finite;
      finite = req_ch.values_finite;
      case (req_ch.func)
         FUNC_LIDAR_POINT: begin
            x  = $signed(req_ch.lidar_x);
            y  = $signed(req_ch.lidar_y);
            ay = (y < 0) ? -y : y;
            if (finite && x > 0 && x <= int'(max_range_r) &&
                longint'(ay) * 256 <= longint'(x) * longint'(tan_front_r) &&
                ay <= int'(half_lane_r) && x < int'(lidar_running))
               lidar_running = x[15:0];
         end
         FUNC_LIDAR_FRAME: begin
            lidar_latched = lidar_running;
            lidar_running = NONE16;
         end
         FUNC_RADAR_DET: begin
            det_range = $signed(req_ch.radar_distance);
            ang       = $signed(req_ch.radar_angle);
            ang_abs   = (ang < 0) ? -ang : ang;
            if (finite && det_range > 0 && det_range <= int'(max_range_r) &&
                ang_abs <= RADAR_ANGLE_LIMIT_Q12 &&
                det_range < int'(radar_running)) begin
               radar_running     = det_range[15:0];
               radar_running_vel = req_ch.radar_rel_vel;
            end
         end
         FUNC_RADAR_FRAME: begin
            radar_latched     = radar_running;
            radar_latched_vel = radar_running_vel;
            radar_running     = NONE16;
            radar_running_vel = '0;
         end
         FUNC_TICK: predict_tick();
         default: ;
      endcase
   endtask

   task automatic check_target();
      speed_word_type want;
      if (expected_targets.size() == 0) begin
         report_mismatch("speed target word with none expected, speed_cmd",
                         int'(rsp_ch.speed_cmd), 0);
      end else begin
         want = expected_targets.pop_front();
         targets_checked++;
         if (want.capped) caps_checked++;
         if (rsp_ch.speed_cmd !== want.speed)
            report_mismatch("speed_cmd", int'(rsp_ch.speed_cmd), int'(want.speed));
         if (rsp_ch.nearest_distance !== want.distance)
            report_mismatch("nearest_distance", int'(rsp_ch.nearest_distance),
                            int'(want.distance));
         if (rsp_ch.obstacle_seen !== want.seen)
            report_mismatch("obstacle_seen", int'(rsp_ch.obstacle_seen), int'(want.seen));
         if (rsp_ch.emergency_cap_applied !== want.capped)
            report_mismatch("emergency_cap_applied", int'(rsp_ch.emergency_cap_applied),
                            int'(want.capped));
      end
   endtask

   // A result taken at the same edge as a tick belongs to an earlier tick,
   // so it is compared before the new prediction is queued.
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_target();
         if (csr_ch.valid && csr_ch.ready) write_setting(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) predict_word();
      end
      pending = expected_targets.size();
   end

endmodule

### verif/obstacle_gated_speed_target_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Obstacle-gated speed target: testbench top
// Drives lidar points, radar detections, frame ends and ticks into the block
// under several register settings, with random gaps on both sides and one
// long result stall, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module obstacle_gated_speed_target_test;
   import ogst_pkg::*;

   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         SETTLE_CYCLES   = 8;
   localparam int         DRAIN_CYCLES    = 12;
   localparam int         LONG_HOLD       = 120;
   localparam int         RANDOM_PHASES   = 5;
   localparam int         WORDS_PER_PHASE = 125;
   localparam logic [2:0] FUNC_SPARE_A    = 3'd5;
   localparam logic [2:0] FUNC_SPARE_B    = 3'd6;
   localparam logic [2:0] FUNC_SPARE_C    = 3'd7;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   targets_checked;
   int   caps_checked;
   int   words_sent;
   int   settings_used;
   int   idle_cycles = 0;
   int   hold_request;
   bit   steady;
   int   cfg_max_range;
   int   cfg_half_lane;

   ogst_req_if req_ch ();
   ogst_rsp_if rsp_ch ();
   ogst_csr_if csr_ch ();

   obstacle_gated_speed_target dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   obstacle_gated_speed_target_checker target_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .failures        (failures),
      .pending         (pending),
      .targets_checked (targets_checked),
      .caps_checked    (caps_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("obstacle_gated_speed_target: mismatch");
            $finish;
         end
      end
   end

   function automatic int rand_s16();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int rand_angle();
      return int'($urandom_range(0, 25736)) - 12868;
   endfunction

   function automatic int rand_vel();
      return int'($urandom_range(0, 32767)) - 16384;
   endfunction

   task automatic send_word(input logic [2:0] f, input int x, input int y,
                            input int range_q8, input int ang, input int vel,
                            input bit finite);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          = 1'b1;
      req_ch.func           = f;
      req_ch.lidar_x        = x[15:0];
      req_ch.lidar_y        = y[15:0];
      req_ch.radar_distance = range_q8[15:0];
      req_ch.radar_angle    = ang[14:0];
      req_ch.radar_rel_vel  = vel[14:0];
      req_ch.values_finite  = finite;
      do @(posedge clock); while (!req_ch.ready);
      if (f <= FUNC_TICK) words_sent++;
   endtask

   // Frame ends, ticks and spare codes carry random payloads the block ignores.
   task automatic send_marker(input logic [2:0] f);
      send_word(f, rand_s16(), rand_s16(), rand_s16(), rand_angle(), rand_vel(),
                $urandom_range(0, 1));
   endtask

   task automatic send_noise();
      send_word(3'($urandom_range(0, 7)), rand_s16(), rand_s16(), rand_s16(), rand_angle(),
                rand_vel(), $urandom_range(0, 1));
   endtask

   task automatic send_random_point();
      int x;
      int y;
      int lim;
      lim = (cfg_half_lane + 64 > 32767) ? 32767 : cfg_half_lane + 64;
      if ($urandom_range(0, 1) == 0) lim = lim / 8;
      if ($urandom_range(0, 9) == 0) x = rand_s16();
      else x = int'($urandom_range(1, (cfg_max_range > 0) ? cfg_max_range : 1));
      y = int'($urandom_range(0, 2 * lim)) - lim;
      send_word(FUNC_LIDAR_POINT, x, y, rand_s16(), rand_angle(), rand_vel(),
                $urandom_range(0, 19) != 0);
   endtask

   task automatic send_random_detection();
      int det_range;
      int ang;
      if ($urandom_range(0, 9) == 0) det_range = rand_s16();
      else det_range = int'($urandom_range(1, (cfg_max_range > 0) ? cfg_max_range : 1));
      if ($urandom_range(0, 3) == 0) ang = rand_angle();
      else ang = int'($urandom_range(0, 10000)) - 5000;
      send_word(FUNC_RADAR_DET, rand_s16(), rand_s16(), det_range, ang, rand_vel(),
                $urandom_range(0, 19) != 0);
   endtask

   task automatic send_scene(input int count);
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 99) < 12) begin
            send_noise();
         end else begin
            repeat ($urandom_range(1, 8)) send_random_point();
            if ($urandom_range(0, 9) != 0) send_marker(FUNC_LIDAR_FRAME);
            repeat ($urandom_range(0, 4)) send_random_detection();
            if ($urandom_range(0, 9) != 0) send_marker(FUNC_RADAR_FRAME);
            send_marker(FUNC_TICK);
         end
      end
   endtask

   // Lidar points keep the block busy after the last result, hence the pause.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value[15:0];
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic apply_settings(input int ms, input int mins, input int stop, input int ih,
                                 input int mr, input int hl, input int tan_front,
                                 input int closure);
      wait_idle();
      write_reg(CSR_MAX_SPEED, ms);
      write_reg(CSR_MIN_SPEED, mins);
      write_reg(CSR_STOP_DISTANCE, stop);
      write_reg(CSR_INV_HEADWAY, ih);
      write_reg(CSR_MAX_RANGE, mr);
      write_reg(CSR_HALF_LANE, hl);
      write_reg(CSR_TAN_FRONT_ANGLE, tan_front);
      write_reg(CSR_EMERGENCY_CLOSURE, closure);
      @(negedge clock);
      csr_ch.valid  = 1'b0;
      cfg_max_range = mr;
      cfg_half_lane = hl;
      settings_used++;
   endtask

   task automatic random_settings();
      int ms;
      int mins;
      int ih;
      int mr;
      int tan_front;
      ms = ($urandom_range(0, 1) == 0) ? $urandom_range(512, 4096) : $urandom_range(0, 16383);
      mins = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                         : $urandom_range(0, ms / 4);
      ih = ($urandom_range(0, 5) == 0) ? $urandom_range(2561, 4095) : $urandom_range(0, 2560);
      mr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                       : $urandom_range(4000, 20000);
      tan_front = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(100, 1000);
      apply_settings(ms, mins, $urandom_range(0, 3000), ih, mr, $urandom_range(0, 2000),
                     tan_front, -int'($urandom_range(0, 16384)));
   endtask

   initial begin : receiver
      int gap;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request != 0) begin
            gap          = hold_request;
            hold_request = 0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 4);
         end
         @(negedge clock);
         if (gap != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stimulus
      int phase;
      reset                 = 1'b1;
      steady                = 1'b0;
      hold_request          = 0;
      words_sent            = 0;
      settings_used         = 1;
      cfg_max_range         = 12800;
      cfg_half_lane         = 448;
      req_ch.valid          = 1'b0;
      req_ch.func           = FUNC_LIDAR_POINT;
      req_ch.lidar_x        = '0;
      req_ch.lidar_y        = '0;
      req_ch.radar_distance = '0;
      req_ch.radar_angle    = '0;
      req_ch.radar_rel_vel  = '0;
      req_ch.values_finite  = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = CSR_MAX_SPEED;
      csr_ch.data           = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed words under the reset settings.
      send_marker(FUNC_TICK);
      send_word(FUNC_LIDAR_POINT, 3000, 100, 0, 0, 0, 1'b1);
      send_word(FUNC_LIDAR_POINT, 0, 0, 0, 0, 0, 1'b1);
      send_word(FUNC_LIDAR_POINT, -32768, -32768, 0, 0, 0, 1'b1);
      send_word(FUNC_LIDAR_POINT, 32767, 0, 0, 0, 0, 1'b1);
      send_word(FUNC_LIDAR_POINT, 12800, 448, 0, 0, 0, 1'b1);
      send_word(FUNC_LIDAR_POINT, 2000, 449, 0, 0, 0, 1'b1);
      send_word(FUNC_LIDAR_POINT, 100, -200, 0, 0, 0, 1'b1);
      send_word(FUNC_LIDAR_POINT, 1500, 0, 0, 0, 0, 1'b0);
      send_marker(FUNC_LIDAR_FRAME);
      send_word(FUNC_RADAR_DET, 0, 0, 2500, 4289, -2000, 1'b1);
      send_word(FUNC_RADAR_DET, 0, 0, 2500, -4289, 16383, 1'b1);
      send_word(FUNC_RADAR_DET, 0, 0, 1000, 4290, 0, 1'b1);
      send_word(FUNC_RADAR_DET, 0, 0, -32768, 0, 0, 1'b1);
      send_word(FUNC_RADAR_DET, 0, 0, 32767, 0, 0, 1'b1);
      send_word(FUNC_RADAR_DET, 0, 0, 800, -12868, -16384, 1'b1);
      send_word(FUNC_RADAR_DET, 0, 0, 600, 12868, -16384, 1'b0);
      send_marker(FUNC_RADAR_FRAME);
      send_marker(FUNC_TICK);
      send_marker(FUNC_SPARE_A);
      send_marker(FUNC_SPARE_B);
      send_marker(FUNC_SPARE_C);
      send_word(FUNC_LIDAR_POINT, 300, 0, 0, 0, 0, 1'b1);
      send_marker(FUNC_LIDAR_FRAME);
      send_marker(FUNC_TICK);
      send_marker(FUNC_RADAR_FRAME);
      send_marker(FUNC_LIDAR_FRAME);
      send_marker(FUNC_TICK);

      // The receiver stalls while ticks keep coming, so the input backs up.
      hold_request = LONG_HOLD;
      steady       = 1'b1;
      repeat (30) begin
         send_random_point();
         send_marker(FUNC_TICK);
      end
      steady = 1'b0;

      apply_settings(16383, 0, 0, 2560, 32767, 32767, 65535, 0);
      send_scene(WORDS_PER_PHASE);
      apply_settings(0, 16383, 32767, 4095, 0, 0, 0, -16384);
      send_scene(WORDS_PER_PHASE);
      apply_settings(3000, 4000, 256, 3000, 20000, 1000, 256, -1);
      steady = 1'b1;
      send_scene(WORDS_PER_PHASE);
      steady = 1'b0;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_settings();
         steady = (phase == 2);
         send_scene(WORDS_PER_PHASE);
         steady = 1'b0;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d sensor and tick words under %0d register settings, with a %0d-cycle %s",
               words_sent, settings_used, LONG_HOLD, "result stall.");
      $display("Checked %0d speed targets, %0d of them lowered by the closure cap.",
               targets_checked, caps_checked);
      if (failures == 0) begin
         $display("obstacle_gated_speed_target: match");
      end else begin
         $display("obstacle_gated_speed_target: mismatch");
      end
      $finish;
   end

endmodule
